FILE: src/phs_pkg.sv
// Shared types, codes and defaults for the partitioned handle set.
package phs_pkg;

	localparam int CAPACITY_DEF     = 256;
	localparam int PAYLOAD_BITS_DEF = 32;

	typedef enum logic [2:0] {
		CMD_INSERT     = 3'd0,
		CMD_REMOVE_H   = 3'd1,
		CMD_REMOVE_L   = 3'd2,
		CMD_TO_NONINF  = 3'd3,
		CMD_TO_INF     = 3'd4,
		CMD_READ_H     = 3'd5,
		CMD_READ_POS   = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_BAD   = 2'd2,
		STS_WRONG = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_LAST, S_LRD, S_VAL, S_RDP, S_CAPD, S_INSW, S_INSS,
		S_SWRA, S_SWRB, S_SWW1, S_SWW2, S_FIN, S_DONE
	} fsm_t;

	// dense store read address
	typedef enum logic [2:0] {
		DS_POS, DS_P, DS_LAST, DS_SA, DS_SB
	} dsel_t;

	typedef enum logic [1:0] {
		SA_P, SA_INFM1, SA_CNTM1
	} sa_t;

	typedef enum logic [1:0] {
		SB_INFM1, SB_CNTM1, SB_INF
	} sb_t;

	typedef enum logic [2:0] {
		FIN_NONE, FIN_INS, FIN_REM, FIN_DEC, FIN_INC
	} fin_t;

	typedef struct packed {
		logic    load;
		logic    link_rd;
		logic    link_sel_h;
		logic    dense_rd;
		dsel_t   dense_sel;
		logic    cap_last;
		logic    cap_p;
		logic    cap_dense;
		logic    ins_write;
		logic    sw_setup;
		sa_t     sa_sel;
		sb_t     sb_sel;
		logic    po_from_sb;
		logic    co_force;
		logic    co_val;
		logic    sw_capa;
		logic    sw_w1;
		logic    sw_w2;
		fin_t    fin;
		logic    out_load;
		status_t status;
	} dp_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic cnt_zero;
		logic pos_bad;
		logic h_ok;
		logic l_lt_inf;
		logic p_lt_inf;
		logic ins_inf;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: src/partitioned_handle_set.sv
// Top level of the partitioned handle set: stream ports, sequencer and datapath.
// An infected insert and a class move each add one swap; a remove adds one swap
// (two for an infected entry), and a remove of the last entry first reads the
// last dense slot. Each swap reads both slots of the dense store, then writes
// them back (steps SWRA, SWRB, SWW1, SWW2). One request at a time; the next is
// taken the cycle after the result is registered. Asynchronous reset clears counts,
// free head and per-handle flags at once; the stores need no clearing pass.
module partitioned_handle_set #(
	parameter int CAPACITY     = phs_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = phs_pkg::PAYLOAD_BITS_DEF,
	localparam int IW  = $clog2(CAPACITY),
	localparam int CW  = $clog2(CAPACITY + 1),
	localparam int SDW = ((2 * IW + PAYLOAD_BITS + 7) / 8) * 8,
	localparam int MDW = ((2 * IW + PAYLOAD_BITS + 3 * CW + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// handle, position, payload, zero fill
	input  logic [SDW-1:0] s_tdata,
	// command[2:0], infected[3]
	input  logic [3:0]     s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	// handle_out, position_out, payload_out, count, infected_count, free_head, zero fill
	output logic [MDW-1:0] m_tdata,
	// status[1:0], infected_out[2]
	output logic [2:0]     m_tuser
);

	localparam int MUSED = 2 * IW + PAYLOAD_BITS + 3 * CW;

	phs_pkg::dp_ctl_t ctl;
	phs_pkg::dp_sts_t sts;

	logic [1:0]              status;
	logic [IW-1:0]           handle_out, position_out;
	logic [PAYLOAD_BITS-1:0] payload_out;
	logic                    infected_out;
	logic [CW-1:0]           count, infected_count, free_head;

	// sequencer: decides each step of a request
	phs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: dense store, link store, counters and the result register
	phs_dp #(
		.CAPACITY     (CAPACITY),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.command        (s_tuser[2:0]),
		.handle         (s_tdata[IW-1:0]),
		.position       (s_tdata[2*IW-1:IW]),
		.payload        (s_tdata[2*IW+PAYLOAD_BITS-1:2*IW]),
		.infected       (s_tuser[3]),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.status         (status),
		.handle_out     (handle_out),
		.position_out   (position_out),
		.payload_out    (payload_out),
		.infected_out   (infected_out),
		.count          (count),
		.infected_count (infected_count),
		.free_head      (free_head)
	);

	// pack the result fields from the lowest bit up, pad to whole bytes
	assign m_tdata = MDW'({free_head, infected_count, count, payload_out,
		position_out, handle_out});
	assign m_tuser = {infected_out, status};

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> MUSED) == '0)
		else $error("result fill bits not zero");

endmodule

FILE: src/phs_ctrl.sv
// Sequencer for the partitioned handle set: walks each request through its steps.
module phs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  phs_pkg::dp_sts_t  sts,
	output phs_pkg::dp_ctl_t  ctl
);

	phs_pkg::fsm_t    state_q, state_d;
	phs_pkg::status_t stat_q, stat_d;
	logic             second_q, second_d;
	logic             is_remove;

	assign is_remove = (sts.cmd == phs_pkg::CMD_REMOVE_H) || (sts.cmd == phs_pkg::CMD_REMOVE_L);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= phs_pkg::S_IDLE;
			stat_q   <= phs_pkg::STS_OK;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			stat_q   <= stat_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		stat_d   = stat_q;
		second_d = second_q;
		unique case (state_q)
			phs_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d  = phs_pkg::S_DEC;
					stat_d   = phs_pkg::STS_OK;
					second_d = 1'b0;
				end
			end
			phs_pkg::S_DEC: begin
				unique case (sts.cmd)
					phs_pkg::CMD_INSERT: begin
						if (sts.full) begin
							stat_d  = phs_pkg::STS_FULL;
							state_d = phs_pkg::S_DONE;
						end else begin
							state_d = phs_pkg::S_INSW;
						end
					end
					phs_pkg::CMD_REMOVE_H, phs_pkg::CMD_TO_NONINF, phs_pkg::CMD_TO_INF,
					phs_pkg::CMD_READ_H: state_d = phs_pkg::S_LRD;
					phs_pkg::CMD_REMOVE_L: begin
						if (sts.cnt_zero) begin
							stat_d  = phs_pkg::STS_BAD;
							state_d = phs_pkg::S_DONE;
						end else begin
							state_d = phs_pkg::S_LAST;
						end
					end
					phs_pkg::CMD_READ_POS: begin
						if (sts.pos_bad) begin
							stat_d  = phs_pkg::STS_BAD;
							state_d = phs_pkg::S_DONE;
						end else begin
							state_d = phs_pkg::S_RDP;
						end
					end
					default: begin
						stat_d  = phs_pkg::STS_BAD;
						state_d = phs_pkg::S_DONE;
					end
				endcase
			end
			phs_pkg::S_LAST: state_d = phs_pkg::S_LRD;
			phs_pkg::S_LRD:  state_d = phs_pkg::S_VAL;
			phs_pkg::S_VAL: begin
				priority if (!sts.h_ok) begin
					stat_d  = phs_pkg::STS_BAD;
					state_d = phs_pkg::S_DONE;
				end else if ((sts.cmd == phs_pkg::CMD_TO_NONINF) && !sts.l_lt_inf) begin
					stat_d  = phs_pkg::STS_WRONG;
					state_d = phs_pkg::S_DONE;
				end else if ((sts.cmd == phs_pkg::CMD_TO_INF) && sts.l_lt_inf) begin
					stat_d  = phs_pkg::STS_WRONG;
					state_d = phs_pkg::S_DONE;
				end else begin
					state_d = phs_pkg::S_RDP;
				end
			end
			phs_pkg::S_RDP: state_d = phs_pkg::S_CAPD;
			phs_pkg::S_CAPD: begin
				if (is_remove || (sts.cmd == phs_pkg::CMD_TO_NONINF) ||
				    (sts.cmd == phs_pkg::CMD_TO_INF)) begin
					state_d = phs_pkg::S_SWRA;
				end else begin
					state_d = phs_pkg::S_DONE;
				end
			end
			phs_pkg::S_INSW: state_d = sts.ins_inf ? phs_pkg::S_INSS : phs_pkg::S_FIN;
			phs_pkg::S_INSS: state_d = phs_pkg::S_SWRA;
			phs_pkg::S_SWRA: state_d = phs_pkg::S_SWRB;
			phs_pkg::S_SWRB: state_d = phs_pkg::S_SWW1;
			phs_pkg::S_SWW1: state_d = phs_pkg::S_SWW2;
			phs_pkg::S_SWW2: begin
				if (is_remove && sts.p_lt_inf && !second_q) begin
					second_d = 1'b1;
					state_d  = phs_pkg::S_SWRA;
				end else begin
					state_d = phs_pkg::S_FIN;
				end
			end
			phs_pkg::S_FIN: state_d = phs_pkg::S_DONE;
			phs_pkg::S_DONE: begin
				if (sts.out_free) state_d = phs_pkg::S_IDLE;
			end
			default: state_d = phs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.dense_sel = phs_pkg::DS_P;
		ctl.sa_sel    = phs_pkg::SA_P;
		ctl.sb_sel    = phs_pkg::SB_CNTM1;
		ctl.fin       = phs_pkg::FIN_NONE;
		ctl.status    = stat_q;
		s_tready      = 1'b0;
		unique case (state_q)
			phs_pkg::S_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid;
			end
			phs_pkg::S_DEC: begin
				if (sts.cmd == phs_pkg::CMD_INSERT) begin
					ctl.link_rd = !sts.full;
				end
				if (sts.cmd == phs_pkg::CMD_REMOVE_L) begin
					ctl.dense_rd  = !sts.cnt_zero;
					ctl.dense_sel = phs_pkg::DS_LAST;
				end
			end
			phs_pkg::S_LAST: ctl.cap_last = 1'b1;
			phs_pkg::S_LRD: begin
				ctl.link_rd    = 1'b1;
				ctl.link_sel_h = 1'b1;
			end
			phs_pkg::S_VAL: ctl.cap_p = 1'b1;
			phs_pkg::S_RDP: begin
				ctl.dense_rd  = 1'b1;
				ctl.dense_sel = (sts.cmd == phs_pkg::CMD_READ_POS) ? phs_pkg::DS_POS : phs_pkg::DS_P;
			end
			phs_pkg::S_CAPD: begin
				ctl.cap_dense = 1'b1;
				ctl.sa_sel    = phs_pkg::SA_P;
				if (is_remove) begin
					ctl.sw_setup = 1'b1;
					ctl.sb_sel   = sts.p_lt_inf ? phs_pkg::SB_INFM1 : phs_pkg::SB_CNTM1;
				end else if (sts.cmd == phs_pkg::CMD_TO_NONINF) begin
					ctl.sw_setup   = 1'b1;
					ctl.sb_sel     = phs_pkg::SB_INFM1;
					ctl.po_from_sb = 1'b1;
					ctl.co_force   = 1'b1;
					ctl.co_val     = 1'b0;
				end else if (sts.cmd == phs_pkg::CMD_TO_INF) begin
					ctl.sw_setup   = 1'b1;
					ctl.sb_sel     = phs_pkg::SB_INF;
					ctl.po_from_sb = 1'b1;
					ctl.co_force   = 1'b1;
					ctl.co_val     = 1'b1;
				end
			end
			phs_pkg::S_INSW: ctl.ins_write = 1'b1;
			phs_pkg::S_INSS: begin
				ctl.sw_setup   = 1'b1;
				ctl.sa_sel     = phs_pkg::SA_CNTM1;
				ctl.sb_sel     = phs_pkg::SB_INF;
				ctl.po_from_sb = 1'b1;
			end
			phs_pkg::S_SWRA: begin
				ctl.dense_rd  = 1'b1;
				ctl.dense_sel = phs_pkg::DS_SA;
			end
			phs_pkg::S_SWRB: begin
				ctl.dense_rd  = 1'b1;
				ctl.dense_sel = phs_pkg::DS_SB;
				ctl.sw_capa   = 1'b1;
			end
			phs_pkg::S_SWW1: ctl.sw_w1 = 1'b1;
			phs_pkg::S_SWW2: begin
				ctl.sw_w2 = 1'b1;
				if (is_remove && sts.p_lt_inf && !second_q) begin
					ctl.sw_setup = 1'b1;
					ctl.sa_sel   = phs_pkg::SA_INFM1;
					ctl.sb_sel   = phs_pkg::SB_CNTM1;
				end
			end
			phs_pkg::S_FIN: begin
				unique case (sts.cmd)
					phs_pkg::CMD_INSERT:    ctl.fin = phs_pkg::FIN_INS;
					phs_pkg::CMD_REMOVE_H,
					phs_pkg::CMD_REMOVE_L:  ctl.fin = phs_pkg::FIN_REM;
					phs_pkg::CMD_TO_NONINF: ctl.fin = phs_pkg::FIN_DEC;
					phs_pkg::CMD_TO_INF:    ctl.fin = phs_pkg::FIN_INC;
					default:                ctl.fin = phs_pkg::FIN_NONE;
				endcase
			end
			phs_pkg::S_DONE: ctl.out_load = sts.out_free;
			default: ctl.out_load = 1'b0;
		endcase
	end

endmodule

FILE: src/phs_dp.sv
// Datapath for the partitioned handle set: stores, counters, swap unit, result register.
module phs_dp #(
	parameter int CAPACITY     = phs_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = phs_pkg::PAYLOAD_BITS_DEF,
	localparam int IW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  phs_pkg::dp_ctl_t        ctl,
	output phs_pkg::dp_sts_t        sts,
	input  logic [2:0]              command,
	input  logic [IW-1:0]           handle,
	input  logic [IW-1:0]           position,
	input  logic [PAYLOAD_BITS-1:0] payload,
	input  logic                    infected,
	input  logic                    m_tready,
	output logic                    m_tvalid,
	output logic [1:0]              status,
	output logic [IW-1:0]           handle_out,
	output logic [IW-1:0]           position_out,
	output logic [PAYLOAD_BITS-1:0] payload_out,
	output logic                    infected_out,
	output logic [CW-1:0]           count,
	output logic [CW-1:0]           infected_count,
	output logic [CW-1:0]           free_head
);

	localparam int EW = IW + PAYLOAD_BITS;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// dense entry: handle in the upper bits, payload below
	logic [EW-1:0] dense_mem [CAPACITY];
	// link entry: active flag on top, then dense position or next free handle
	logic [CW:0]   link_mem  [CAPACITY];

	phs_pkg::cmd_t         cmd_q;
	logic [IW-1:0]         h_q, pos_q, p_q, sa_q, sb_q, ho_q, po_q;
	logic [PAYLOAD_BITS-1:0] pin_q, pay_q;
	logic                  iin_q, co_q;
	logic [EW-1:0]         a_q;
	logic [CW-1:0]         cnt_q, inf_q, head_q;
	logic [CAPACITY-1:0]   lv_q;
	logic                  out_valid_q;

	logic [CW:0]           link_rd_s1;
	logic                  lv_s1;
	logic [IW-1:0]         laddr_s1;
	logic [EW-1:0]         dense_rd_s1;
	logic [IW-1:0]         dra_s1;

	logic [CW-1:0]         link_eff, cnt_m1, inf_m1;
	logic                  link_act;
	logic [IW-1:0]         link_ra, dense_ra, sa_d, sb_d;
	logic                  lw_en, dw_en;
	logic [IW-1:0]         lw_addr, dw_addr;
	logic [CW:0]           lw_data;
	logic [EW-1:0]         dw_data;
	logic [IW-1:0]         rd_handle, a_handle;

	assign cnt_m1    = cnt_q - CW'(1);
	assign inf_m1    = inf_q - CW'(1);
	assign link_eff  = lv_s1 ? link_rd_s1[CW-1:0] : (CW'(laddr_s1) + CW'(1));
	assign link_act  = lv_s1 && link_rd_s1[CW];
	assign rd_handle = dense_rd_s1[EW-1:PAYLOAD_BITS];
	assign a_handle  = a_q[EW-1:PAYLOAD_BITS];
	assign link_ra   = ctl.link_sel_h ? h_q : head_q[IW-1:0];

	always_comb begin
		unique case (ctl.dense_sel)
			phs_pkg::DS_POS:  dense_ra = pos_q;
			phs_pkg::DS_P:    dense_ra = p_q;
			phs_pkg::DS_LAST: dense_ra = cnt_m1[IW-1:0];
			phs_pkg::DS_SA:   dense_ra = sa_q;
			phs_pkg::DS_SB:   dense_ra = sb_q;
			default:          dense_ra = p_q;
		endcase
		unique case (ctl.sa_sel)
			phs_pkg::SA_P:     sa_d = p_q;
			phs_pkg::SA_INFM1: sa_d = inf_m1[IW-1:0];
			phs_pkg::SA_CNTM1: sa_d = cnt_m1[IW-1:0];
			default:           sa_d = p_q;
		endcase
		unique case (ctl.sb_sel)
			phs_pkg::SB_INFM1: sb_d = inf_m1[IW-1:0];
			phs_pkg::SB_CNTM1: sb_d = cnt_m1[IW-1:0];
			phs_pkg::SB_INF:   sb_d = inf_q[IW-1:0];
			default:           sb_d = cnt_m1[IW-1:0];
		endcase
	end

	// one write a cycle to each store
	always_comb begin
		lw_en   = 1'b1;
		lw_addr = h_q;
		lw_data = {1'b0, head_q};
		priority if (ctl.ins_write) begin
			lw_addr = head_q[IW-1:0];
			lw_data = {1'b1, cnt_q};
		end else if (ctl.sw_w1) begin
			lw_addr = rd_handle;
			lw_data = {1'b1, CW'(sa_q)};
		end else if (ctl.sw_w2) begin
			lw_addr = a_handle;
			lw_data = {1'b1, CW'(sb_q)};
		end else if (ctl.fin == phs_pkg::FIN_REM) begin
			lw_addr = h_q;
			lw_data = {1'b0, head_q};
		end else begin
			lw_en = 1'b0;
		end

		dw_en   = 1'b1;
		dw_addr = sa_q;
		dw_data = dense_rd_s1;
		priority if (ctl.ins_write) begin
			dw_addr = cnt_q[IW-1:0];
			dw_data = {head_q[IW-1:0], pin_q};
		end else if (ctl.sw_w1) begin
			dw_addr = sa_q;
			dw_data = dense_rd_s1;
		end else if (ctl.sw_w2) begin
			dw_addr = sb_q;
			dw_data = a_q;
		end else begin
			dw_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.link_rd) begin
			link_rd_s1 <= link_mem[link_ra];
			lv_s1      <= lv_q[link_ra];
			laddr_s1   <= link_ra;
		end
		if (lw_en) link_mem[lw_addr] <= lw_data;
	end

	always_ff @(posedge clk) begin
		if (ctl.dense_rd) begin
			dense_rd_s1 <= dense_mem[dense_ra];
			dra_s1      <= dense_ra;
		end
		if (dw_en) dense_mem[dw_addr] <= dw_data;
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= phs_pkg::cmd_t'(command);
			h_q   <= handle;
			pos_q <= position;
			pin_q <= payload;
			iin_q <= infected;
		end
		if (ctl.cap_last) h_q <= rd_handle;
		if (ctl.cap_p)    p_q <= link_eff[IW-1:0];
		if (ctl.cap_dense) begin
			ho_q  <= rd_handle;
			pay_q <= dense_rd_s1[PAYLOAD_BITS-1:0];
			po_q  <= dra_s1;
			co_q  <= (CW'(dra_s1) < inf_q);
		end
		if (ctl.ins_write) begin
			ho_q  <= head_q[IW-1:0];
			pay_q <= pin_q;
			po_q  <= cnt_q[IW-1:0];
			co_q  <= iin_q;
		end
		if (ctl.sw_setup) begin
			sa_q <= sa_d;
			sb_q <= sb_d;
			if (ctl.po_from_sb) po_q <= sb_d;
		end
		if (ctl.co_force) co_q <= ctl.co_val;
		if (ctl.sw_capa)  a_q  <= dense_rd_s1;
	end

	// counters, free list head and per-handle written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			inf_q    <= '0;
			head_q   <= '0;
			lv_q     <= '0;
		end else begin
			if (lw_en) lv_q[lw_addr] <= 1'b1;
			if (ctl.ins_write) begin
				head_q <= link_eff;
				cnt_q  <= cnt_q + CW'(1);
			end
			unique case (ctl.fin)
				phs_pkg::FIN_INS: if (iin_q) inf_q <= inf_q + CW'(1);
				phs_pkg::FIN_REM: begin
					cnt_q  <= cnt_m1;
					if (CW'(p_q) < inf_q) inf_q <= inf_m1;
					head_q <= CW'(h_q);
				end
				phs_pkg::FIN_DEC: inf_q <= inf_m1;
				phs_pkg::FIN_INC: inf_q <= inf_q + CW'(1);
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status         <= ctl.status;
			count          <= cnt_q;
			infected_count <= inf_q;
			free_head      <= head_q;
			if (ctl.status == phs_pkg::STS_OK) begin
				handle_out   <= ho_q;
				position_out <= po_q;
				payload_out  <= pay_q;
				infected_out <= co_q;
			end else begin
				handle_out   <= '0;
				position_out <= '0;
				payload_out  <= '0;
				infected_out <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	assign sts.cmd      = cmd_q;
	assign sts.full     = (head_q >= CAP_C) || (cnt_q >= CAP_C);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.pos_bad  = (CW'(pos_q) >= cnt_q);
	assign sts.h_ok     = (CW'(h_q) < CAP_C) && link_act && (link_eff < cnt_q);
	assign sts.l_lt_inf = (link_eff < inf_q);
	assign sts.p_lt_inf = (CW'(p_q) < inf_q);
	assign sts.ins_inf  = iin_q;
	assign sts.out_free = !out_valid_q || m_tready;

	a_inf_le_cnt: assert property (@(posedge clk) disable iff (!arst_n) inf_q <= cnt_q)
		else $error("infected count above active count");
	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP_C)
		else $error("active count above capacity");
	a_free_full: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == CAP_C) == (cnt_q == CAP_C))
		else $error("free list and active count disagree");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_write |-> !(ctl.sw_w1 || ctl.sw_w2 || ctl.out_load))
		else $error("insert write overlaps another store write");

endmodule

FILE: test/partitioned_handle_set_test.sv
// Testbench for the partitioned handle set: directed and random command streams checked against a model.
`timescale 1ns / 100ps

module partitioned_handle_set_test;

	localparam int CAP = 256;
	localparam int SDW = 48;
	localparam int MDW = 80;
	localparam int RANDOM_REQUESTS = 1030;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  handle;
		logic [7:0]  position;
		logic [31:0] payload;
		logic        infected;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  handle;
		logic [7:0]  position;
		logic [31:0] payload;
		logic        infected;
		logic [8:0]  count;
		logic [8:0]  inf_count;
		logic [8:0]  free_head;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SDW-1:0] s_tdata = '0;
	logic [3:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MDW-1:0] m_tdata;
	logic [2:0] m_tuser;

	partitioned_handle_set uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the set
	logic [7:0]  dense_handle [CAP];
	logic [31:0] dense_payload [CAP];
	int          link [CAP];
	bit          live [CAP];
	int          live_count, inf_total, free_first;

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	int failures = 0;
	int cycles = 0;
	int accepted = 0;

	function automatic void set_reset();
		for (int i = 0; i < CAP; i++) begin
			dense_handle[i] = '0;
			dense_payload[i] = '0;
			link[i] = i + 1;
			live[i] = 1'b0;
		end
		live_count = 0;
		inf_total = 0;
		free_first = 0;
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [7:0] th;
		logic [31:0] tp;
		if (a == b) return;
		th = dense_handle[a]; dense_handle[a] = dense_handle[b]; dense_handle[b] = th;
		tp = dense_payload[a]; dense_payload[a] = dense_payload[b]; dense_payload[b] = tp;
		link[dense_handle[a]] = a;
		link[dense_handle[b]] = b;
	endfunction

	function automatic bit handle_live(int h);
		return live[h] && link[h] < live_count;
	endfunction

	// Apply one request to the shadow set and give the outcome it should produce
	function automatic outcome_t apply_command(request_t rq);
		outcome_t o;
		int h, p;
		o = '0;
		h = rq.handle;
		case (rq.command)
			phs_pkg::CMD_INSERT: begin
				if (free_first >= CAP) o.status = phs_pkg::STS_FULL;
				else begin
					o.handle = 8'(free_first);
					free_first = link[o.handle];
					p = live_count;
					dense_handle[p] = o.handle;
					dense_payload[p] = rq.payload;
					link[o.handle] = p;
					live[o.handle] = 1'b1;
					live_count++;
					if (rq.infected) begin
						swap_slots(p, inf_total);
						p = inf_total;
						inf_total++;
					end
					o.position = 8'(p);
					o.payload = rq.payload;
					o.infected = rq.infected;
				end
			end
			phs_pkg::CMD_REMOVE_H, phs_pkg::CMD_REMOVE_L: begin
				if (rq.command == phs_pkg::CMD_REMOVE_L) begin
					if (live_count == 0) o.status = phs_pkg::STS_BAD;
					else h = dense_handle[live_count - 1];
				end
				if (o.status == phs_pkg::STS_OK && !handle_live(h)) o.status = phs_pkg::STS_BAD;
				if (o.status == phs_pkg::STS_OK) begin
					p = link[h];
					o.handle = 8'(h);
					o.position = 8'(p);
					o.payload = dense_payload[p];
					if (p < inf_total) begin
						o.infected = 1'b1;
						swap_slots(p, inf_total - 1);
						swap_slots(inf_total - 1, live_count - 1);
						inf_total--;
					end else
						swap_slots(p, live_count - 1);
					live_count--;
					live[h] = 1'b0;
					link[h] = free_first;
					free_first = h;
				end
			end
			phs_pkg::CMD_TO_NONINF, phs_pkg::CMD_TO_INF: begin
				if (!handle_live(h)) o.status = phs_pkg::STS_BAD;
				else if ((rq.command == phs_pkg::CMD_TO_NONINF) != (link[h] < inf_total))
					o.status = phs_pkg::STS_WRONG;
				else begin
					if (rq.command == phs_pkg::CMD_TO_NONINF) begin
						swap_slots(link[h], inf_total - 1);
						inf_total--;
					end else begin
						swap_slots(link[h], inf_total);
						inf_total++;
					end
					o.handle = 8'(h);
					o.position = 8'(link[h]);
					o.payload = dense_payload[link[h]];
					o.infected = (rq.command == phs_pkg::CMD_TO_INF);
				end
			end
			phs_pkg::CMD_READ_H: begin
				if (!handle_live(h)) o.status = phs_pkg::STS_BAD;
				else begin
					o.handle = 8'(h);
					o.position = 8'(link[h]);
					o.payload = dense_payload[link[h]];
					o.infected = link[h] < inf_total;
				end
			end
			phs_pkg::CMD_READ_POS: begin
				if (rq.position >= live_count) o.status = phs_pkg::STS_BAD;
				else begin
					o.handle = dense_handle[rq.position];
					o.position = rq.position;
					o.payload = dense_payload[rq.position];
					o.infected = rq.position < inf_total;
				end
			end
			default: o.status = phs_pkg::STS_BAD;
		endcase
		o.count = 9'(live_count);
		o.inf_count = 9'(inf_total);
		o.free_head = 9'(free_first);
		return o;
	endfunction

	function automatic request_t make_request(phs_pkg::cmd_t c, int h, int p, logic [31:0] pay,
		bit inf);
		request_t rq;
		rq.command = c;
		rq.handle = 8'(h);
		rq.position = 8'(p);
		rq.payload = pay;
		rq.infected = inf;
		return rq;
	endfunction

	function automatic void queue_request(request_t rq);
		pending_requests.insert(pending_requests.size(), rq);
	endfunction

	// Random command weighted towards live handles; bias inserts by fill level
	function automatic request_t random_request(int fill_bias);
		request_t rq;
		int pick;
		rq.payload = $urandom;
		rq.infected = 1'($urandom_range(0, 1));
		rq.position = 8'($urandom_range(0, 255));
		rq.handle = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < fill_bias) rq.command = phs_pkg::CMD_INSERT;
		else if (pick < 97) rq.command = 3'($urandom_range(1, 6));
		else rq.command = 3'd7;
		if ($urandom_range(0, 3) != 0 && live_count > 0) begin
			rq.handle = dense_handle[$urandom_range(0, live_count - 1)];
			if (rq.command == phs_pkg::CMD_READ_POS)
				rq.position = 8'($urandom_range(0, live_count - 1));
		end
		return rq;
	endfunction

	// Driver: bursts of requests with random gaps, changes on the falling edge
	int burst_left = 0;
	int gap_left = 0;
	int offered = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			// hold a request that is still waiting to be taken
			if (!s_tvalid || accepted == offered) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {pending_requests[0].payload, pending_requests[0].position,
						pending_requests[0].handle};
					s_tuser <= {pending_requests[0].infected, pending_requests[0].command};
					offered++;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
					end
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Predict at the accept edge, from the request being presented, and drop it
	always @(posedge clk) begin
		request_t taken;
		if (arst_n && s_tvalid && s_tready) begin
			taken = pending_requests.pop_front();
			expected_outcomes.insert(expected_outcomes.size(), apply_command(taken));
			accepted++;
		end
	end

	// Receiver stall pattern, with one long hold-off in the fill-to-capacity phase
	int ready_phase = 0;
	int long_stall = 0;
	bit long_stall_done = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			ready_phase++;
			if (!long_stall_done && accepted >= 400) begin
				long_stall_done = 1'b1;
				long_stall = 400;
			end
			if (long_stall > 0) begin
				long_stall--;
				m_tready <= 1'b0;
			end else if ((ready_phase / 64) % 3 == 0)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) < 60);
		end
	end

	// Monitor: compare each accepted outcome field by field
	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser[1:0];
			got.infected = m_tuser[2];
			{got.free_head, got.inf_count, got.count, got.payload, got.position, got.handle}
				= m_tdata[74:0];
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected outcome %h", $time, got);
				failures++;
			end else begin
				want = expected_outcomes.pop_front();
				if (got.status != want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.handle != want.handle)
					$display("%0t: handle exp %0d got %0d", $time, want.handle, got.handle);
				if (got.position != want.position)
					$display("%0t: position exp %0d got %0d", $time, want.position,
						got.position);
				if (got.payload != want.payload)
					$display("%0t: payload exp %h got %h", $time, want.payload, got.payload);
				if (got.infected != want.infected)
					$display("%0t: class exp %0d got %0d", $time, want.infected, got.infected);
				if (got.count != want.count)
					$display("%0t: count exp %0d got %0d", $time, want.count, got.count);
				if (got.inf_count != want.inf_count)
					$display("%0t: infected count exp %0d got %0d", $time, want.inf_count,
						got.inf_count);
				if (got.free_head != want.free_head)
					$display("%0t: free head exp %0d got %0d", $time, want.free_head,
						got.free_head);
				if (got != want) failures++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int fill_bias;
		request_t rq;
		set_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty-set errors, extremes, every command
		queue_request(make_request(phs_pkg::CMD_REMOVE_L, 0, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_READ_POS, 0, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_READ_H, 255, 255, '1, 1));
		queue_request(make_request(phs_pkg::cmd_t'(3'd7), 0, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_INSERT, 0, 0, 32'hFFFF_FFFF, 0));
		queue_request(make_request(phs_pkg::CMD_INSERT, 255, 255, 32'h0, 1));
		queue_request(make_request(phs_pkg::CMD_INSERT, 0, 0, 32'hA5A5_5A5A, 1));
		queue_request(make_request(phs_pkg::CMD_TO_INF, 1, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_TO_NONINF, 2, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_TO_INF, 2, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_TO_INF, 0, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_READ_POS, 0, 2, '0, 0));
		queue_request(make_request(phs_pkg::CMD_READ_POS, 0, 3, '0, 0));
		queue_request(make_request(phs_pkg::CMD_READ_H, 1, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_REMOVE_H, 2, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_REMOVE_H, 2, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_REMOVE_L, 0, 0, '0, 0));
		queue_request(make_request(phs_pkg::CMD_INSERT, 0, 0, 32'h1234_5678, 0));

		// Let the directed part drain, then pause until every result is back
		wait (pending_requests.size() == 0);
		wait (expected_outcomes.size() == 0);
		repeat (20) @(posedge clk);

		// Random part: generated against the shadow state as the driver consumes it
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			// wait for the driver so that generation sees the current state
			wait (pending_requests.size() < 2);
			@(posedge clk);
			// phase the fill level: grow, fill to capacity, churn, drain
			if (i < 300) fill_bias = 55;
			else if (i < 600) fill_bias = 95;
			else if (i < 800) fill_bias = 25;
			else fill_bias = 5;
			rq = random_request(fill_bias);
			queue_request(rq);
		end
		wait (pending_requests.size() == 0);
		wait (expected_outcomes.size() == 0);
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
